FILE: sv/egi_pkg.sv
// Shared types, constants and the luminance quantizer of the edge-aware glyph indexer.
package egi_pkg;

  localparam logic [1:0] CfgLineWidth   = 2'd0;
  localparam logic [1:0] CfgFrameHeight = 2'd1;
  localparam logic [1:0] CfgQuantLevels = 2'd2;

  localparam logic [3:0] GlyphSteep   = 4'd10;
  localparam logic [3:0] GlyphFalling = 4'd11;
  localparam logic [3:0] GlyphFlat    = 4'd12;
  localparam logic [3:0] GlyphRising  = 4'd13;

  localparam logic [20:0] EdgeThresholdSq = 21'd160000;
  localparam logic [7:0]  DarkLimit       = 8'd192;
  localparam logic [9:0]  SteepSlopeQ8    = 10'd788;
  localparam logic [6:0]  FlatSlopeQ8     = 7'd83;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_CLASS,
    ST_EMIT_INT,
    ST_EMIT_BRD
  } state_e;

  typedef struct packed {
    logic accept;
    logic shift;
    logic grad;
    logic classify;
    logic emit_int;
  } cmd_t;

  typedef struct packed {
    logic interior;
    logic border;
  } status_t;

  // Level is the count of multiples of the step size that the scaled grey reaches.
  function automatic logic [3:0] lumin_level(logic [7:0] grey, logic [3:0] levels);
    logic [14:0] div;
    logic [17:0] prod;
    logic [17:0] bound;
    logic [3:0]  lvl;
    case (levels)
      4'd2:    div = 15'd25500;
      4'd3:    div = 15'd12750;
      4'd4:    div = 15'd8500;
      4'd5:    div = 15'd6375;
      4'd6:    div = 15'd5100;
      4'd7:    div = 15'd4250;
      4'd8:    div = 15'd3642;
      4'd9:    div = 15'd3187;
      default: div = 15'd2833;
    endcase
    prod = 18'(grey) * 18'd100;
    lvl  = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      bound = 18'(div) * 18'(k);
      if (prod >= bound) begin
        lvl = lvl + 4'd1;
      end
    end
    return lvl;
  endfunction

endpackage

FILE: sv/egi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module egi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: sv/egi_ctrl.sv
// Controller state machine sequencing one item through read, gradient, classify and emit.
module egi_ctrl import egi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_READ;
      ST_READ:  state_d = ST_GRAD;
      ST_GRAD:  state_d = ST_CLASS;
      ST_CLASS: begin
        if (status_i.interior) state_d = ST_EMIT_INT;
        else if (status_i.border) state_d = ST_EMIT_BRD;
        else state_d = ST_IDLE;
      end
      ST_EMIT_INT: begin
        if (!out_stall_i) state_d = status_i.border ? ST_EMIT_BRD : ST_IDLE;
      end
      ST_EMIT_BRD: if (!out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o      = (state_q != ST_IDLE);
    out_valid_o     = (state_q == ST_EMIT_INT) || (state_q == ST_EMIT_BRD);
    cmd_o.accept    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.shift     = (state_q == ST_READ);
    cmd_o.grad      = (state_q == ST_GRAD);
    cmd_o.classify  = (state_q == ST_CLASS);
    cmd_o.emit_int  = (state_q == ST_EMIT_INT);
  end

endmodule

FILE: sv/egi_datapath.sv
// Datapath: configuration, position counters, line buffers, window, Sobel and glyph choice.
module egi_datapath import egi_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [10:0]   cfg_data_i,
  input  logic [7:0]    grey_level_i,
  input  cmd_t          cmd_i,
  output status_t       status_o,
  output logic [9:0]    cell_row_o,
  output logic [9:0]    cell_column_o,
  output logic [3:0]    glyph_index_o,
  output logic          last_of_run_o
);

  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int WW = $clog2(MAX_LINE_WIDTH + 1);

  logic [10:0] line_width_q, frame_height_q;
  logic [3:0]  quant_levels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= 11'd80;
      frame_height_q <= 11'd60;
      quant_levels_q <= 4'd10;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgLineWidth:   line_width_q   <= cfg_data_i;
        CfgFrameHeight: frame_height_q <= cfg_data_i;
        CfgQuantLevels: quant_levels_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] wdt;
  logic [10:0]   hgt;
  logic [3:0]    lv;

  always_comb begin
    if (line_width_q == 11'd0) wdt = WW'(1);
    else if (32'(line_width_q) > 32'(MAX_LINE_WIDTH)) wdt = WW'(MAX_LINE_WIDTH);
    else wdt = WW'(line_width_q);
    if (frame_height_q == 11'd0) hgt = 11'd1;
    else if (frame_height_q > 11'd1024) hgt = 11'd1024;
    else hgt = frame_height_q;
    if (quant_levels_q < 4'd2) lv = 4'd2;
    else if (quant_levels_q > 4'd10) lv = 4'd10;
    else lv = quant_levels_q;
  end

  logic [CW-1:0] col_q, col_d, c, c_q;
  logic [9:0]    row_q, row_d, r, r_q;
  logic [7:0]    grey_q;
  status_t       status_q;

  always_comb begin
    c = (WW'(col_q) < wdt) ? col_q : CW'(wdt - WW'(1));
    r = ({1'b0, row_q} < hgt) ? row_q : 10'(hgt - 11'd1);
    if ((WW'(c) + WW'(1)) >= wdt) begin
      col_d = '0;
      row_d = (({1'b0, r} + 11'd1) >= hgt) ? 10'd0 : r + 10'd1;
    end else begin
      col_d = c + CW'(1);
      row_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      c_q               <= c;
      r_q               <= r;
      grey_q            <= grey_level_i;
      status_q.interior <= (r >= 10'd2) && (c >= CW'(2));
      status_q.border   <= (r == 10'd0) || (c == '0) || ({1'b0, r} == hgt - 11'd1) ||
                           (WW'(c) == wdt - WW'(1));
    end
  end

  assign status_o = status_q;

  logic [15:0] line_rd;

  egi_ram #(.WIDTH(16), .DEPTH(MAX_LINE_WIDTH)) u_lines (
    .clk_i   (clk_i),
    .we_i    (cmd_i.shift),
    .waddr_i (c_q),
    .wdata_i ({line_rd[7:0], grey_q}),
    .re_i    (cmd_i.accept),
    .raddr_i (c),
    .rdata_o (line_rd)
  );

  logic [7:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= 8'd0;
    end else if (cmd_i.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2] <= line_rd[15:8];
      win_q[5] <= line_rd[7:0];
      win_q[8] <= grey_q;
    end
  end

  logic [9:0]         xp, xn, yp, yn;
  logic signed [10:0] gx_q, gy_q;

  always_comb begin
    xp = 10'(win_q[2]) + {1'b0, win_q[5], 1'b0} + 10'(win_q[8]);
    xn = 10'(win_q[0]) + {1'b0, win_q[3], 1'b0} + 10'(win_q[6]);
    yp = 10'(win_q[6]) + {1'b0, win_q[7], 1'b0} + 10'(win_q[8]);
    yn = 10'(win_q[0]) + {1'b0, win_q[1], 1'b0} + 10'(win_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      gx_q <= $signed({1'b0, xp}) - $signed({1'b0, xn});
      gy_q <= $signed({1'b0, yp}) - $signed({1'b0, yn});
    end
  end

  logic [9:0]  bx, by;
  logic [20:0] mag;
  logic [19:0] a, steep_b;
  logic [17:0] flat_b;
  logic        edge_hit;
  logic [3:0]  center_glyph;
  logic [3:0]  center_glyph_q, border_glyph_q;

  always_comb begin
    bx       = gx_q[10] ? 10'(-gx_q) : gx_q[9:0];
    by       = gy_q[10] ? 10'(-gy_q) : gy_q[9:0];
    mag      = (21'(bx) * 21'(bx)) + (21'(by) * 21'(by));
    edge_hit = (mag > EdgeThresholdSq) || ((mag == EdgeThresholdSq) && !gx_q[10]);
    a        = {2'b0, by, 8'b0};
    steep_b  = 20'(bx) * 20'(SteepSlopeQ8);
    flat_b   = 18'(bx) * 18'(FlatSlopeQ8);
    if (edge_hit && (win_q[4] < DarkLimit)) begin
      if (a > steep_b) center_glyph = GlyphSteep;
      else if (by == 10'd0) center_glyph = GlyphFlat;
      else if (gy_q[10] != gx_q[10])
        center_glyph = (a[17:0] > flat_b) ? GlyphFalling : GlyphFlat;
      else center_glyph = (a[17:0] >= flat_b) ? GlyphRising : GlyphFlat;
    end else begin
      center_glyph = lumin_level(win_q[4], lv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      center_glyph_q <= center_glyph;
      border_glyph_q <= lumin_level(grey_q, lv);
    end
  end

  always_comb begin
    if (cmd_i.emit_int) begin
      cell_row_o    = r_q - 10'd1;
      cell_column_o = 10'(c_q - CW'(1));
      glyph_index_o = center_glyph_q;
      last_of_run_o = !status_q.border;
    end else begin
      cell_row_o    = r_q;
      cell_column_o = 10'(c_q);
      glyph_index_o = border_glyph_q;
      last_of_run_o = 1'b1;
    end
  end

endmodule

FILE: sv/edge_aware_glyph_index.sv
// Top level of the edge-aware glyph indexer: Sobel edge glyphs and luminance levels per cell.
//
//   channel   signals                                   direction
//   input     in_valid_i, in_stall_o, grey_level_i      in
//   output    out_valid_o, out_stall_i, cell_row_o,     out
//             cell_column_o, glyph_index_o, last_of_run_o
//   config    cfg_we_i, cfg_index_i, cfg_data_i         in
//
// Each item steps through line buffer read, window shift, gradient and classify, then
// one emit state per result (none, one or two); an output stall holds the emit state.
// The single line buffer RAM port pair and the sequencer set this sequence.
// Reset clears counters and window and loads the default configuration; the line buffers are not cleared.
// The input is stalled until all results of the current item have been taken.
module edge_aware_glyph_index import egi_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  grey_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  cell_row_o,
  output logic [9:0]  cell_column_o,
  output logic [3:0]  glyph_index_o,
  output logic        last_of_run_o
);

  cmd_t    cmd;
  status_t status;

  egi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  egi_datapath #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .grey_level_i  (grey_level_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .cell_row_o    (cell_row_o),
    .cell_column_o (cell_column_o),
    .glyph_index_o (glyph_index_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
